// ===== src/srl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted record list package
// Shared field widths, action and status codes, and parameter defaults for
// the sorted record list and its record store.
// ----------------------------------------------------------------------------
package srl_pkg;

    // Parameter defaults.
    localparam int DEPTH_DEF      = 64;
    localparam int SCORE_BITS_DEF = 16;

    // Fixed field widths of the command and result ports.
    localparam int ID_W       = 16;
    localparam int IN_SCORE_W = 16;
    localparam int HOURS_W    = 8;
    localparam int IDX_W      = 6;
    localparam int ACTION_W   = 3;
    localparam int STATUS_W   = 2;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SORT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    // Width of one stored record: id, score and hours packed together.
    function automatic int rec_width(input int score_bits);
        return ID_W + score_bits + HOURS_W;
    endfunction

endpackage
`default_nettype wire

// ===== src/srl_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted record list store
// Record memory with one write port and one read port. Read data is
// registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module srl_mem #(
    parameter int DEPTH = srl_pkg::DEPTH_DEF,
    parameter int WIDTH = srl_pkg::rec_width(srl_pkg::SCORE_BITS_DEF),
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== src/sorted_record_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted record list
// Bounded list of (id, score, hours) records held in a memory. Supports
// append, sorted insert, stable descending sort, indexed read and clear.
// One score comparator is reused by a small sequencer for every search step.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Signals
//  command   start & !busy          i_action, i_rec_id, i_rec_score,
//                                   i_rec_hours, i_read_index
//  result    o_done, one cycle      o_status, o_entry_count, o_out_id,
//                                   o_out_score, o_out_hours
//
//  Append, clear, unused actions, rejected transactions and a sort of at most
//  one record finish straight from idle. A read, an insert and a longer sort
//  step through the sequencer states; their length is set by the single
//  memory read port and its registered read data.
//  Reset is synchronous and active low; it empties the list.
//  Busy stays high while a transaction is in progress; the receiver cannot
//  stall, the result is shown for exactly the cycle o_done is high.
// ----------------------------------------------------------------------------
module sorted_record_list #(
    parameter int DEPTH      = srl_pkg::DEPTH_DEF,
    parameter int SCORE_BITS = srl_pkg::SCORE_BITS_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [srl_pkg::ACTION_W-1:0]    i_action,
    input  wire logic [srl_pkg::ID_W-1:0]        i_rec_id,
    input  wire logic [srl_pkg::IN_SCORE_W-1:0]  i_rec_score,
    input  wire logic [srl_pkg::HOURS_W-1:0]     i_rec_hours,
    input  wire logic [srl_pkg::IDX_W-1:0]       i_read_index,
    output logic                                 o_done,
    output logic      [srl_pkg::STATUS_W-1:0]    o_status,
    output logic      [CW-1:0]                   o_entry_count,
    output logic      [srl_pkg::ID_W-1:0]        o_out_id,
    output logic      [srl_pkg::IN_SCORE_W-1:0]  o_out_score,
    output logic      [srl_pkg::HOURS_W-1:0]     o_out_hours
);

    import srl_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = ID_W + SCORE_BITS + HOURS_W;
    localparam int SC_LO = HOURS_W;
    localparam int ID_LO = HOURS_W + SCORE_BITS;
    localparam int XW    = (CW > IDX_W) ? CW : IDX_W;
    localparam int EW    = SCORE_BITS + IN_SCORE_W;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_READ_WT  = 10'b00_0000_0010,
        S_SCAN_RD  = 10'b00_0000_0100,
        S_SCAN_CK  = 10'b00_0000_1000,
        S_SHIFT_RD = 10'b00_0001_0000,
        S_SHIFT_WR = 10'b00_0010_0000,
        S_SORT_LD  = 10'b00_0100_0000,
        S_SORT_KEY = 10'b00_1000_0000,
        S_SORT_RD  = 10'b01_0000_0000,
        S_SORT_CK  = 10'b10_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_pos,   n_pos;
    logic [CW-1:0]        r_k,     n_k;
    logic [CW-1:0]        r_i,     n_i;
    logic [CW-1:0]        r_j,     n_j;
    logic [RW-1:0]        r_rec,   n_rec;
    logic                 r_done,  n_done;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [ID_W-1:0]      r_out_id, n_out_id;
    logic [IN_SCORE_W-1:0] r_out_score, n_out_score;
    logic [HOURS_W-1:0]   r_out_hours, n_out_hours;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [RW-1:0]        wr_data;
    logic [AW-1:0]        rd_addr;
    logic [RW-1:0]        rd_data;

    logic [EW-1:0]        in_score_ext;
    logic [RW-1:0]        in_rec;
    logic [EW-1:0]        rd_score_ext;
    logic                 rd_lt;
    logic                 full;
    logic [XW-1:0]        idx_ext;
    logic                 idx_bad;
    logic [CW-1:0]        k_m1;
    logic [CW-1:0]        j_m1;

    // Record store.
    srl_mem #(
        .DEPTH (DEPTH),
        .WIDTH (RW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Incoming record with the score fitted to the stored width.
    assign in_score_ext = {{SCORE_BITS{1'b0}}, i_rec_score};
    assign in_rec       = {i_rec_id, in_score_ext[SCORE_BITS-1:0], i_rec_hours};
    assign rd_score_ext = {{IN_SCORE_W{1'b0}}, rd_data[SC_LO +: SCORE_BITS]};

    // Shared comparator: stored score below the held record's score.
    assign rd_lt = rd_data[SC_LO +: SCORE_BITS] < r_rec[SC_LO +: SCORE_BITS];

    assign full    = (r_count == CW'(DEPTH));
    assign idx_ext = XW'(i_read_index);
    assign idx_bad = idx_ext >= XW'(r_count);
    assign k_m1    = r_k - CW'(1);
    assign j_m1    = r_j - CW'(1);

    // Sequencer next-state and memory port control.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_rec       = r_rec;
        n_done      = 1'b0;
        n_status    = r_status;
        n_out_id    = r_out_id;
        n_out_score = r_out_score;
        n_out_hours = r_out_hours;
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        wr_data     = r_rec;
        rd_addr     = r_pos[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status    = ST_OK;
                    n_out_id    = '0;
                    n_out_score = '0;
                    n_out_hours = '0;
                    n_rec       = in_rec;
                    case (i_action)
                        ACT_APPEND: begin
                            n_done = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[AW-1:0];
                                wr_data = in_rec;
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_INSERT: begin
                            if (full) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_pos   = '0;
                                n_state = S_SCAN_RD;
                            end
                        end
                        ACT_SORT: begin
                            if (r_count <= CW'(1)) begin
                                n_done = 1'b1;
                            end else begin
                                n_i     = CW'(1);
                                n_state = S_SORT_LD;
                            end
                        end
                        ACT_READ: begin
                            if (idx_bad) begin
                                n_done   = 1'b1;
                                n_status = ST_BAD_INDEX;
                            end else begin
                                rd_addr = idx_ext[AW-1:0];
                                n_state = S_READ_WT;
                            end
                        end
                        ACT_CLEAR: begin
                            n_done  = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            // Read data is back; report it.
            S_READ_WT: begin
                n_done      = 1'b1;
                n_out_id    = rd_data[ID_LO +: ID_W];
                n_out_score = rd_score_ext[IN_SCORE_W-1:0];
                n_out_hours = rd_data[HOURS_W-1:0];
                n_state     = S_IDLE;
            end

            // Insert: search from the head for the first lower score.
            S_SCAN_RD: begin
                if (r_pos == r_count) begin
                    n_k     = r_count;
                    n_state = S_SHIFT_RD;
                end else begin
                    rd_addr = r_pos[AW-1:0];
                    n_state = S_SCAN_CK;
                end
            end

            S_SCAN_CK: begin
                if (!rd_lt) begin
                    n_pos   = r_pos + CW'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    n_k     = r_count;
                    n_state = S_SHIFT_RD;
                end
            end

            // Insert: move the tail up one slot, then drop the record in.
            S_SHIFT_RD: begin
                if (r_k == r_pos) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[AW-1:0];
                    wr_data = r_rec;
                    n_count = r_count + CW'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr = k_m1[AW-1:0];
                    n_state = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k[AW-1:0];
                wr_data = rd_data;
                n_k     = k_m1;
                n_state = S_SHIFT_RD;
            end

            // Sort: pick up the next key record.
            S_SORT_LD: begin
                if (r_i == r_count) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr = r_i[AW-1:0];
                    n_state = S_SORT_KEY;
                end
            end

            S_SORT_KEY: begin
                n_rec   = rd_data;
                n_j     = r_i;
                n_state = S_SORT_RD;
            end

            // Sort: walk toward the head past lower scores.
            S_SORT_RD: begin
                if (r_j == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = r_rec;
                    n_i     = r_i + CW'(1);
                    n_state = S_SORT_LD;
                end else begin
                    rd_addr = j_m1[AW-1:0];
                    n_state = S_SORT_CK;
                end
            end

            S_SORT_CK: begin
                wr_en   = 1'b1;
                wr_addr = r_j[AW-1:0];
                if (rd_lt) begin
                    wr_data = rd_data;
                    n_j     = j_m1;
                    n_state = S_SORT_RD;
                end else begin
                    wr_data = r_rec;
                    n_i     = r_i + CW'(1);
                    n_state = S_SORT_LD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_k         <= n_k;
        r_i         <= n_i;
        r_j         <= n_j;
        r_rec       <= n_rec;
        r_status    <= n_status;
        r_out_id    <= n_out_id;
        r_out_score <= n_out_score;
        r_out_hours <= n_out_hours;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_count = r_count;
    assign o_out_id      = r_out_id;
    assign o_out_score   = r_out_score;
    assign o_out_hours   = r_out_hours;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted record list testbench
// Drives append, sorted insert, sort, read, clear and spare command codes
// into the record list through its start/busy handshake. A scoreboard class
// keeps its own copy of the list, predicts every result and checks each
// o_done strobe field by field. Random episodes grow the list (sometimes up
// to full and beyond), may sort it, read it back and mostly clear it.
// ----------------------------------------------------------------------------
module tb;
    import srl_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int CNT_W        = $clog2(LIST_DEPTH + 1);
    localparam int TOTAL_ITEMS  = 1950;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 40000;
    localparam int MAX_PRINTS   = 40;

    // Action codes that the block ignores.
    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_MID   = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [IN_SCORE_W-1:0] score;
        logic [HOURS_W-1:0]    hours;
    } t_record;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        t_record             rec;
        logic [IDX_W-1:0]    index;
    } t_command;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
        t_record             rec;
    } t_result;

    // Shadow list, expected results and mismatch bookkeeping.
    class list_tracker;
        t_record slots[LIST_DEPTH];
        int      held;
        t_result expected_q[$];
        int      mismatches;
        int      checked;
        int      full_rejects;
        int      bad_reads;
        int      action_seen[8];

        function new();
            held = 0;
            mismatches = 0;
            checked = 0;
            full_rejects = 0;
            bad_reads = 0;
            foreach (action_seen[a]) action_seen[a] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Shift the tail up by one and drop the record in at pos.
        function void place_at(int pos, t_record r);
            int k;
            for (k = held; k > pos; k--) slots[k] = slots[k - 1];
            slots[pos] = r;
            held++;
        endfunction

        // Work out the result of one accepted command and queue it.
        function void note_command(t_command c);
            t_result exp_r;
            t_record hold_r;
            int      pos;
            int      i;
            int      j;
            exp_r = '0;
            exp_r.status = ST_OK;
            action_seen[c.action]++;
            case (c.action)
                ACT_APPEND: begin
                    if (held >= LIST_DEPTH) exp_r.status = ST_FULL;
                    else place_at(held, c.rec);
                end
                ACT_INSERT: begin
                    if (held >= LIST_DEPTH) begin
                        exp_r.status = ST_FULL;
                    end else begin
                        // Land after every record with a score at least as high.
                        pos = 0;
                        while (pos < held && slots[pos].score >= c.rec.score) pos++;
                        place_at(pos, c.rec);
                    end
                end
                ACT_SORT: begin
                    // Stable insertion sort, highest score first.
                    for (i = 1; i < held; i++) begin
                        hold_r = slots[i];
                        j = i;
                        while (j > 0 && slots[j - 1].score < hold_r.score) begin
                            slots[j] = slots[j - 1];
                            j--;
                        end
                        slots[j] = hold_r;
                    end
                end
                ACT_READ: begin
                    if (int'(c.index) >= held) exp_r.status = ST_BAD_INDEX;
                    else exp_r.rec = slots[c.index];
                end
                ACT_CLEAR: held = 0;
                default: ;
            endcase
            if (exp_r.status == ST_FULL) full_rejects++;
            if (exp_r.status == ST_BAD_INDEX) bad_reads++;
            exp_r.count = CNT_W'(held);
            expected_q.push_back(exp_r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            if (mismatches < MAX_PRINTS)
                $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                         checked, what, got, want);
            mismatches++;
        endtask

        // Compare one strobed result with the oldest expectation.
        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", 32'(got), 0);
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.count !== want.count)
                    report_mismatch("entry_count", 32'(got.count), 32'(want.count));
                if (got.rec.id !== want.rec.id)
                    report_mismatch("out_id", 32'(got.rec.id), 32'(want.rec.id));
                if (got.rec.score !== want.rec.score)
                    report_mismatch("out_score", 32'(got.rec.score), 32'(want.rec.score));
                if (got.rec.hours !== want.rec.hours)
                    report_mismatch("out_hours", 32'(got.rec.hours), 32'(want.rec.hours));
            end
            checked++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [ACTION_W-1:0]   i_action;
    logic [ID_W-1:0]       i_rec_id;
    logic [IN_SCORE_W-1:0] i_rec_score;
    logic [HOURS_W-1:0]    i_rec_hours;
    logic [IDX_W-1:0]      i_read_index;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [CNT_W-1:0]      o_entry_count;
    logic [ID_W-1:0]       o_out_id;
    logic [IN_SCORE_W-1:0] o_out_score;
    logic [HOURS_W-1:0]    o_out_hours;

    list_tracker sb;
    int          idle_cycles;
    int          list_len;
    int          items_sent;
    bit          gaps_on;

    sorted_record_list dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_rec_id      (i_rec_id),
        .i_rec_score   (i_rec_score),
        .i_rec_hours   (i_rec_hours),
        .i_read_index  (i_read_index),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_out_id      (o_out_id),
        .o_out_score   (o_out_score),
        .o_out_hours   (o_out_hours)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: note accepted commands before checking results of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note_command('{i_action, '{i_rec_id, i_rec_score, i_rec_hours},
                              i_read_index});
        end
        if (i_rst_n && o_done) begin
            sb.check_result('{o_status, o_entry_count,
                              '{o_out_id, o_out_score, o_out_hours}});
        end
        if (i_rst_n && ((start && !busy) || o_done)) idle_cycles = 0;
        else idle_cycles++;
    end

    // Watchdog: stop the run when nothing moves for too long.
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic t_command make_cmd(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                                          logic [IN_SCORE_W-1:0] score,
                                          logic [HOURS_W-1:0] hours,
                                          logic [IDX_W-1:0] index);
        t_command c;
        c.action    = act;
        c.rec.id    = id;
        c.rec.score = score;
        c.rec.hours = hours;
        c.index     = index;
        return c;
    endfunction

    // Random fields; scores lean toward extremes and a few small values so
    // that equal scores are common.
    function automatic t_command rand_cmd(logic [ACTION_W-1:0] act);
        logic [IN_SCORE_W-1:0] score;
        case ($urandom_range(0, 5))
            0:       score = '0;
            1:       score = '1;
            2, 3:    score = IN_SCORE_W'($urandom_range(0, 7));
            default: score = IN_SCORE_W'($urandom);
        endcase
        return make_cmd(act, ID_W'($urandom), score, HOURS_W'($urandom),
                        IDX_W'($urandom_range(0, 63)));
    endfunction

    // Present one command, after a random gap when gaps are on, and hold it until accepted.
    task automatic send_command(t_command c);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= c.action;
        i_rec_id     <= c.rec.id;
        i_rec_score  <= c.rec.score;
        i_rec_hours  <= c.rec.hours;
        i_read_index <= c.index;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (c.action)
            ACT_APPEND, ACT_INSERT: if (list_len < LIST_DEPTH) list_len++;
            ACT_CLEAR:              list_len = 0;
            default: ;
        endcase
        if (c.action <= ACT_CLEAR) items_sent++;
    endtask

    task automatic send_read(int index);
        t_command c;
        c = rand_cmd(ACT_READ);
        c.index = IDX_W'(index);
        send_command(c);
    endtask

    // Stop sending until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int  episode;
        int  adds;
        int  insert_pct;
        int  k;
        bit  grow_full;
        t_command c;

        sb          = new();
        idle_cycles = 0;
        list_len    = 0;
        items_sent  = 0;
        gaps_on     = 1'b0;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= ACT_APPEND;
        i_rec_id     <= '0;
        i_rec_score  <= '0;
        i_rec_hours  <= '0;
        i_read_index <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, extremes, equal scores, stable sort, bad reads.
        send_read(0);
        send_command(make_cmd(ACT_SORT, '0, '0, '0, '0));
        send_command(make_cmd(ACT_CLEAR, '0, '0, '0, '0));
        send_command(make_cmd(ACT_APPEND, '1, '1, '1, '0));
        send_command(make_cmd(ACT_APPEND, '0, '0, '0, '1));
        send_command(make_cmd(ACT_INSERT, 16'h0001, 16'h8000, 8'h55, '0));
        send_command(make_cmd(ACT_INSERT, 16'h0002, '1, 8'h11, '0));
        send_command(make_cmd(ACT_INSERT, 16'h0003, '0, 8'h22, '0));
        send_command(make_cmd(ACT_APPEND, 16'h0004, 16'h7FFF, 8'hAA, '0));
        send_command(make_cmd(ACT_APPEND, 16'h0005, '1, 8'h33, '0));
        send_command(make_cmd(ACT_SORT, '1, '1, '1, '1));
        for (k = 0; k < 7; k++) send_read(k);
        send_read(7);
        send_read(63);
        send_command(make_cmd(ACT_SPARE_FIRST, '1, '1, '1, '1));
        send_command(make_cmd(ACT_SPARE_MID, '1, '1, '1, '1));
        send_command(make_cmd(ACT_SPARE_LAST, '1, '1, '1, '1));
        send_command(make_cmd(ACT_CLEAR, '1, '1, '1, '1));
        send_read(0);
        drain_results();

        // Random episodes: grow the list, maybe sort, read it back, maybe clear.
        episode = 0;
        while (items_sent < TOTAL_ITEMS) begin
            gaps_on    = ($urandom_range(0, 3) != 0);
            grow_full  = ($urandom_range(0, 9) == 0);
            adds       = grow_full ? (LIST_DEPTH - list_len + $urandom_range(1, 3))
                                   : $urandom_range(1, 12);
            insert_pct = $urandom_range(0, 100);
            for (k = 0; k < adds; k++) begin
                send_command(rand_cmd(($urandom_range(0, 99) < insert_pct) ?
                                      ACT_INSERT : ACT_APPEND));
                case ($urandom_range(0, 29))
                    0:       send_command(rand_cmd(ACT_SORT));
                    1: begin
                        c = rand_cmd(ACT_SPARE_FIRST);
                        c.action = ACTION_W'($urandom_range(ACT_SPARE_FIRST,
                                                            ACT_SPARE_LAST));
                        send_command(c);
                    end
                    2, 3, 4, 5, 6, 7, 8, 9: send_read($urandom_range(0, list_len));
                    10:      send_read($urandom_range(0, 63));
                    default: ;
                endcase
            end
            if ($urandom_range(0, 1) == 1) send_command(rand_cmd(ACT_SORT));
            for (k = 0; k < list_len; k++) send_read(k);
            if (list_len < LIST_DEPTH) send_read($urandom_range(list_len, 63));
            if (episode == 0 || $urandom_range(0, 3) == 0) drain_results();
            if ($urandom_range(0, 4) != 0) send_command(rand_cmd(ACT_CLEAR));
            episode++;
        end

        // Let the last results come back, then a few quiet cycles.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch("results never arrived", 32'(sb.pending()), 0);

        $display({"ran %0d episodes: %0d appends, %0d inserts, %0d sorts, ",
                  "%0d reads, %0d clears, %0d spare codes"},
                 episode, sb.action_seen[ACT_APPEND], sb.action_seen[ACT_INSERT],
                 sb.action_seen[ACT_SORT], sb.action_seen[ACT_READ],
                 sb.action_seen[ACT_CLEAR],
                 sb.action_seen[ACT_SPARE_FIRST] + sb.action_seen[ACT_SPARE_MID] +
                 sb.action_seen[ACT_SPARE_LAST]);
        $display({"%0d results checked, %0d rejected on a full list, ",
                  "%0d reads past the count, %0d mismatches"},
                 sb.checked, sb.full_rejects, sb.bad_reads, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
